[rtl/crcfe_pkg.sv]
// Package for the CRC-32 frame encapsulator: payload types, link codes and CRC step.
package crcfe_pkg;

	localparam logic [8:0]  LINK_START = 9'h133;
	localparam logic [8:0]  LINK_END   = 9'h144;
	localparam logic [7:0]  BYTE_MASK  = 8'hFF;
	localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       end_of_packet;
	} item_t;

	typedef struct packed {
		logic [8:0] link_word;
		logic       last_of_run;
	} link_t;

	// MSB-first CRC-32 over one byte, data bits entering LSB first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
		logic [31:0] crc;
		logic        fb;
		crc = crc_in;
		for (int k = 0; k < 8; k++) begin
			fb  = crc[31] ^ data[k];
			crc = {crc[30:0], 1'b0};
			if (fb) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

endpackage

[rtl/crc32_frame_encapsulator.sv]
// Packet framer: start marker, payload bytes, CRC-32 trailer and end marker.
// The byte is registered in the input stage, and its first link word then in the output register.
// Throughput: one input byte per cycle for middle bytes while link_ready does not stall;
// a first byte yields two link words, a last byte six and the byte of a one-byte
// packet seven, each sent through the single-word output register.
// Reset (arst_n low, asynchronous): both stages empty, between packets, CRC all ones.
module crc32_frame_encapsulator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  crcfe_pkg::item_t     item,
	output logic                 link_valid,
	input  logic                 link_ready,
	output crcfe_pkg::link_t     link
);
	import crcfe_pkg::*;

	// word positions within the run caused by one byte
	localparam logic [2:0] WPOS_START = 3'd0;
	localparam logic [2:0] WPOS_DATA  = 3'd1;
	localparam logic [2:0] WPOS_CRC3  = 3'd2;
	localparam logic [2:0] WPOS_CRC2  = 3'd3;
	localparam logic [2:0] WPOS_CRC1  = 3'd4;
	localparam logic [2:0] WPOS_CRC0  = 3'd5;
	localparam logic [2:0] WPOS_END   = 3'd6;

	logic        inside_q;
	logic [31:0] crc_q;

	logic        valid_s1;
	logic [2:0]  pos_s1;
	logic        eop_s1;
	logic [7:0]  byte_s1;
	logic [31:0] crc_s1;

	logic        out_valid_q;
	link_t       out_q;

	logic        accept;
	logic        adv;
	logic        word_last;
	logic [8:0]  word;
	logic [31:0] crc_base;
	logic [31:0] crc_next;

	// CRC update at transaction time
	assign crc_base = inside_q ? crc_q : CRC_INIT;
	assign crc_next = crc_byte(crc_base, item.payload_byte & BYTE_MASK);

	// word select for the held item
	always_comb begin
		case (pos_s1)
			WPOS_START: word = LINK_START;
			WPOS_DATA:  word = {1'b0, byte_s1};
			WPOS_CRC3:  word = {1'b0, crc_s1[31:24]};
			WPOS_CRC2:  word = {1'b0, crc_s1[23:16]};
			WPOS_CRC1:  word = {1'b0, crc_s1[15:8]};
			WPOS_CRC0:  word = {1'b0, crc_s1[7:0]};
			WPOS_END:   word = LINK_END;
			default:    word = LINK_END;
		endcase
	end

	assign word_last  = eop_s1 ? (pos_s1 == WPOS_END) : (pos_s1 == WPOS_DATA);
	assign adv        = valid_s1 && (!out_valid_q || link_ready);
	assign item_ready = !valid_s1 || (adv && word_last);
	assign accept     = item_valid && item_ready;

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			crc_q    <= CRC_INIT;
		end else if (accept) begin
			if (item.end_of_packet) begin
				inside_q <= 1'b0;
				crc_q    <= CRC_INIT;
			end else begin
				inside_q <= 1'b1;
				crc_q    <= crc_next;
			end
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_s1   <= WPOS_START;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			pos_s1   <= inside_q ? WPOS_DATA : WPOS_START;
		end else if (adv && word_last) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			pos_s1 <= pos_s1 + 3'd1;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			eop_s1  <= item.end_of_packet;
			byte_s1 <= item.payload_byte;
			crc_s1  <= crc_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (link_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.link_word   <= word;
			out_q.last_of_run <= word_last;
		end
	end

	assign link_valid = out_valid_q;
	assign link       = out_q;

endmodule
